[rtl/lsbfr_pkg.sv]
package lsbfr_pkg;

   // payload widths of the request and response channels
   localparam int OP_W    = 2;
   localparam int BYTE_W  = 8;
   localparam int SIZE_W  = 6;
   localparam int VALUE_W = 32;
   localparam int STAT_W  = 2;

   // request operation codes
   typedef enum logic [OP_W-1:0] {
      OP_PUSH   = 2'd0,
      OP_READ_U = 2'd1,
      OP_READ_S = 2'd2
   } op_type;

   // response status codes
   typedef enum logic [STAT_W-1:0] {
      ST_OK       = 2'd0,
      ST_UNDERRUN = 2'd1,
      ST_FULL     = 2'd2,
      ST_BAD_SIZE = 2'd3
   } status_type;

   // outcome of one request, passed from the datapath to the top level
   typedef struct packed {
      logic                 emit;
      status_type           status;
      logic [VALUE_W-1:0]   value;
   } result_type;

endpackage

[rtl/lsbfr_core.sv]
module lsbfr_core #(
   parameter int STORE_BITS = 64
) (
   input  logic [lsbfr_pkg::OP_W-1:0]        op,
   input  logic [lsbfr_pkg::BYTE_W-1:0]      data_byte,
   input  logic [lsbfr_pkg::SIZE_W-1:0]      field_size,
   input  logic [STORE_BITS-1:0]             store,
   input  logic [$clog2(STORE_BITS+1)-1:0]   count,
   output logic [STORE_BITS-1:0]             store_in,
   output logic [$clog2(STORE_BITS+1)-1:0]   count_in,
   output lsbfr_pkg::result_type             result
);
   import lsbfr_pkg::*;

   localparam int CW        = $clog2(STORE_BITS + 1);
   localparam int MAX_FIELD = 32;

   // low n bits set, n from 0 to 32
   function automatic logic [VALUE_W-1:0] low_mask(input logic [SIZE_W-1:0] n);
      logic [VALUE_W-1:0] m;
      if (n == '0) begin
         m = '0;
      end else begin
         m = {VALUE_W{1'b1}} >> (SIZE_W'(MAX_FIELD) - n);
      end
      return m;
   endfunction

   logic                 full;
   logic                 too_big;
   logic                 underrun;
   logic [SIZE_W-1:0]    mag_size;
   logic [VALUE_W-1:0]   low_word;
   logic [VALUE_W-1:0]   mag;

   // condition checks
   assign full     = ({1'b0, count} + (CW+1)'(BYTE_W)) > (CW+1)'(STORE_BITS);
   assign too_big  = field_size > SIZE_W'(MAX_FIELD);
   assign underrun = count < CW'(field_size);

   // field extraction from the low end of the store
   assign low_word = store[VALUE_W-1:0];
   assign mag_size = field_size - SIZE_W'(1);
   assign mag      = (low_word >> 1) & low_mask(mag_size);

   // next state and result
   always_comb begin
      store_in      = store;
      count_in      = count;
      result.emit   = 1'b0;
      result.status = ST_OK;
      result.value  = '0;
      unique case (op)
         OP_PUSH: begin
            if (full) begin
               result.emit   = 1'b1;
               result.status = ST_FULL;
            end else begin
               store_in = store | (STORE_BITS'(data_byte) << count);
               count_in = count + CW'(BYTE_W);
            end
         end
         OP_READ_U: begin
            result.emit = 1'b1;
            priority if (too_big) begin
               result.status = ST_BAD_SIZE;
            end else if (underrun) begin
               result.status = ST_UNDERRUN;
            end else begin
               result.value = low_word & low_mask(field_size);
               store_in     = store >> field_size;
               count_in     = count - CW'(field_size);
            end
         end
         OP_READ_S: begin
            result.emit = 1'b1;
            priority if (too_big || field_size == '0) begin
               result.status = ST_BAD_SIZE;
            end else if (underrun) begin
               result.status = ST_UNDERRUN;
            end else begin
               result.value = low_word[0] ? ~mag : mag;
               store_in     = store >> field_size;
               count_in     = count - CW'(field_size);
            end
         end
         default: begin
            // unused code: no state change, no response
         end
      endcase
   end

endmodule

[rtl/lsb_first_bit_field_reader.sv]
// lsb_first_bit_field_reader: unpacks bit fields, least significant bit
// first, from a stream of pushed bytes.
// The request channel (req_) carries an operation, a byte and a field
// size. A push appends the byte above the buffered bits and gives no
// response unless the store is full. An unsigned or signed read of up
// to 32 bits always gives one response on the rsp_ channel with the
// field value and a status (ok, not enough bits, store full, bad size).
// Failed requests leave the buffered bits untouched and return zero.
// A transfer happens on a rising edge with valid high and stall low.
// A request taken at a transfer lands in the input register, and its
// response is then registered in the output register. Throughput: one
// request per cycle while no response is held by rsp_stall, set by the
// combinational shift, mask and count update of the bit store.
// When rsp_stall holds a waiting response, the request in the input
// register waits with it, pushes included; req_stall rises while a
// request sits in the input register behind the held response.
// Synchronous reset empties the store and drops any pending request and
// response.
module lsb_first_bit_field_reader #(
   parameter int STORE_BITS = 64
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [lsbfr_pkg::OP_W-1:0]         req_operation,
   input  logic [lsbfr_pkg::BYTE_W-1:0]       req_data_byte,
   input  logic [lsbfr_pkg::SIZE_W-1:0]       req_field_size,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [lsbfr_pkg::VALUE_W-1:0]      rsp_field_value,
   output logic [lsbfr_pkg::STAT_W-1:0]       rsp_status
);
   import lsbfr_pkg::*;

   localparam int CW = $clog2(STORE_BITS + 1);

   logic                  in_valid_ff;
   logic [OP_W-1:0]       in_op_ff;
   logic [BYTE_W-1:0]     in_byte_ff;
   logic [SIZE_W-1:0]     in_size_ff;

   logic [STORE_BITS-1:0] store_ff;
   logic [STORE_BITS-1:0] store_in;
   logic [CW-1:0]         count_ff;
   logic [CW-1:0]         count_in;

   logic                  out_valid_ff;
   logic [VALUE_W-1:0]    out_value_ff;
   status_type            out_status_ff;

   result_type            result;
   logic                  advance;
   logic                  in_take;

   // the stage moves whenever the output register is free or draining
   assign advance   = !out_valid_ff || !rsp_stall;
   assign req_stall = in_valid_ff && !advance;
   assign in_take   = req_valid && !req_stall;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (in_take) begin
         in_op_ff   <= req_operation;
         in_byte_ff <= req_data_byte;
         in_size_ff <= req_field_size;
      end
   end

   // single-pass datapath
   lsbfr_core #(
      .STORE_BITS (STORE_BITS)
   ) u_core (
      .op         (in_op_ff),
      .data_byte  (in_byte_ff),
      .field_size (in_size_ff),
      .store      (store_ff),
      .count      (count_ff),
      .store_in   (store_in),
      .count_in   (count_in),
      .result     (result)
   );

   // bit store state
   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         count_ff <= '0;
      end else if (in_valid_ff && advance) begin
         store_ff <= store_in;
         count_ff <= count_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= in_valid_ff && result.emit;
      end
      if (advance && in_valid_ff && result.emit) begin
         out_value_ff  <= result.value;
         out_status_ff <= result.status;
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_field_value = out_value_ff;
   assign rsp_status      = out_status_ff;

   // the store never holds more bits than it has room for
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(STORE_BITS))
      else $error("bit count above store capacity");

   // a failed request returns a zero field
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> rsp_field_value == '0)
      else $error("nonzero field on failed request");

   // a stall is raised only with a request waiting behind a held response
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> in_valid_ff && out_valid_ff && rsp_stall)
      else $error("stall without a held response");

   // a processed push that fits grows the count by one byte
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance && in_op_ff == OP_PUSH && !result.emit
      |=> count_ff == $past(count_ff) + CW'(BYTE_W))
      else $error("push did not add a byte to the count");

endmodule

[tb/sv/lsb_first_bit_field_reader_tb.sv]
module lsb_first_bit_field_reader_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lsbfr_pkg::*;

   localparam int STORE_BITS      = 64;
   localparam int BYTE_BITS       = 8;
   localparam int FIELD_MAX       = 32;
   localparam int RESET_CYCLES    = 10;
   localparam int DRAIN_CYCLES    = 10;
   localparam int HOLD_CYCLES     = 150;
   localparam int WATCHDOG_CYCLES = 2000;
   localparam int RANDOM_ITEMS    = 1125;
   localparam int DIRECTED_ROWS   = 24;

   // operation code that the block ignores
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

   typedef struct {
      logic [VALUE_W-1:0] value;
      status_type         status;
   } field_result_type;

   typedef struct {
      logic [OP_W-1:0]    op;
      logic [BYTE_W-1:0]  data;
      logic [SIZE_W-1:0]  size;
      bit                 fixed;
      logic [VALUE_W-1:0] value;
      status_type         status;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [OP_W-1:0]     req_operation = OP_PUSH;
   logic [BYTE_W-1:0]   req_data_byte = '0;
   logic [SIZE_W-1:0]   req_field_size = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VALUE_W-1:0]  rsp_field_value;
   logic [STAT_W-1:0]   rsp_status;

   // shadow copy of the bit store
   logic [STORE_BITS-1:0] shadow_bits = '0;
   int                    shadow_count = 0;

   field_result_type pending_fields[$];
   int            fault_count = 0;
   int            sent_count = 0;
   int            checked_count = 0;
   int            status_tally[4] = '{0, 0, 0, 0};
   int            stuck_cycles = 0;
   bit            steady = 1'b0;
   bit            hold_request = 1'b0;

   lsb_first_bit_field_reader #(
      .STORE_BITS(STORE_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_data_byte(req_data_byte),
      .req_field_size(req_field_size),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_field_value(rsp_field_value),
      .rsp_status(rsp_status)
   );

   always #2 clock = ~clock;

   // mostly short gaps, a few long ones, none in steady stretches
   function automatic int pick_gap();
      int r;
      if (steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // expected outcome of one request, updates the shadow store
   task automatic unpack_model(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                               input logic [SIZE_W-1:0] size, output bit emits,
                               output field_result_type res);
      logic [VALUE_W-1:0] raw;
      logic [VALUE_W-1:0] mag;
      emits = 1'b1;
      res.value = '0;
      res.status = ST_OK;
      raw = shadow_bits[VALUE_W-1:0] & ((size == 0) ? 32'h0 : (32'hFFFF_FFFF >> (32 - size)));
      case (op)
         OP_PUSH: begin
            if (shadow_count + BYTE_BITS > STORE_BITS) begin
               res.status = ST_FULL;
            end else begin
               shadow_bits = shadow_bits | (STORE_BITS'(data) << shadow_count);
               shadow_count += BYTE_BITS;
               emits = 1'b0;
            end
         end
         OP_READ_U: begin
            if (size > FIELD_MAX) begin
               res.status = ST_BAD_SIZE;
            end else if (shadow_count < size) begin
               res.status = ST_UNDERRUN;
            end else begin
               res.value = raw;
               shadow_bits = shadow_bits >> size;
               shadow_count -= size;
            end
         end
         OP_READ_S: begin
            if (size == 0 || size > FIELD_MAX) begin
               res.status = ST_BAD_SIZE;
            end else if (shadow_count < size) begin
               res.status = ST_UNDERRUN;
            end else begin
               // sign in the lowest bit, magnitude above it
               mag = raw >> 1;
               res.value = raw[0] ? ~mag : mag;
               shadow_bits = shadow_bits >> size;
               shadow_count -= size;
            end
         end
         default: begin
            emits = 1'b0;
         end
      endcase
   endtask

   // offer one request, wait for the transfer, record what it should give
   task automatic send(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data,
                       input logic [SIZE_W-1:0] size, input bit fixed,
                       input logic [VALUE_W-1:0] fixed_value, input status_type fixed_status);
      bit               emits;
      field_result_type res;
      req_valid <= 1'b1;
      req_operation <= op;
      req_data_byte <= data;
      req_field_size <= size;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      unpack_model(op, data, size, emits, res);
      if (emits) begin
         if (fixed) begin
            res.value = fixed_value;
            res.status = fixed_status;
         end
         pending_fields.push_back(res);
      end
      sent_count++;
      @(negedge clock);
   endtask

   task automatic rest(input int cycles);
      if (cycles > 0) begin
         req_valid <= 1'b0;
         repeat (cycles) @(negedge clock);
      end
   endtask

   // receiver stall, with one long hold-off on request
   initial begin
      int stall_left;
      int hold_left;
      stall_left = 0;
      hold_left = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_left = HOLD_CYCLES;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            stall_left = pick_gap();
         end
      end
   end

   // response check and watchdog
   always @(posedge clock) begin
      field_result_type exp_res;
      if (!reset) begin
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall))
            stuck_cycles = 0;
         else
            stuck_cycles++;
         if (stuck_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: no transfer for %0d cycles, %0d responses outstanding",
                     $time, stuck_cycles, pending_fields.size());
            $display("[lsb_first_bit_field_reader] ERROR");
            $finish;
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_fields.size() == 0) begin
               $display("%0t: unexpected response value %h status %0d",
                        $time, rsp_field_value, rsp_status);
               fault_count++;
            end else begin
               exp_res = pending_fields.pop_front();
               checked_count++;
               status_tally[rsp_status]++;
               if (rsp_field_value !== exp_res.value) begin
                  $display("%0t: field_value expected %h actual %h",
                           $time, exp_res.value, rsp_field_value);
                  fault_count++;
               end
               if (rsp_status !== exp_res.status) begin
                  $display("%0t: status expected %0d actual %0d",
                           $time, exp_res.status, rsp_status);
                  fault_count++;
               end
            end
         end
      end
   end

   // stimulus
   initial begin
      stim_row_type      dir_rows[DIRECTED_ROWS];
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] data;
      logic [SIZE_W-1:0] size;
      int             n;
      int             pick;
      int             lo;
      int             hi;

      // edge cases first: empty store, bad sizes, ignored code, fill, full, wide reads
      dir_rows = '{
         '{OP_READ_U, 8'h00, 6'd0,  1'b1, 32'h0, ST_OK},
         '{OP_READ_U, 8'h00, 6'd1,  1'b1, 32'h0, ST_UNDERRUN},
         '{OP_READ_S, 8'h00, 6'd0,  1'b1, 32'h0, ST_BAD_SIZE},
         '{OP_READ_U, 8'hFF, 6'd33, 1'b1, 32'h0, ST_BAD_SIZE},
         '{OP_READ_S, 8'hFF, 6'd63, 1'b1, 32'h0, ST_BAD_SIZE},
         '{OP_UNUSED, 8'hFF, 6'd63, 1'b0, 32'h0, ST_OK},
         '{OP_PUSH,   8'hFF, 6'd0,  1'b0, 32'h0, ST_OK},
         '{OP_PUSH,   8'h00, 6'd63, 1'b0, 32'h0, ST_OK},
         '{OP_PUSH,   8'hA5, 6'd0,  1'b0, 32'h0, ST_OK},
         '{OP_PUSH,   8'h3C, 6'd0,  1'b0, 32'h0, ST_OK},
         '{OP_READ_S, 8'h00, 6'd1,  1'b0, 32'h0, ST_OK},
         '{OP_READ_U, 8'h00, 6'd7,  1'b0, 32'h0, ST_OK},
         '{OP_READ_S, 8'h00, 6'd8,  1'b0, 32'h0, ST_OK},
         '{OP_READ_U, 8'h00, 6'd32, 1'b0, 32'h0, ST_OK},
         '{OP_PUSH,   8'h80, 6'd0,  1'b0, 32'h0, ST_OK},
         '{OP_PUSH,   8'h7F, 6'd0,  1'b0, 32'h0, ST_OK},
         '{OP_PUSH,   8'h01, 6'd0,  1'b0, 32'h0, ST_OK},
         '{OP_PUSH,   8'hFE, 6'd0,  1'b0, 32'h0, ST_OK},
         '{OP_PUSH,   8'h55, 6'd0,  1'b0, 32'h0, ST_OK},
         '{OP_PUSH,   8'hAA, 6'd0,  1'b0, 32'h0, ST_OK},
         '{OP_PUSH,   8'h12, 6'd0,  1'b1, 32'h0, ST_FULL},
         '{OP_READ_S, 8'h00, 6'd32, 1'b0, 32'h0, ST_OK},
         '{OP_READ_U, 8'h00, 6'd32, 1'b0, 32'h0, ST_OK},
         '{OP_READ_S, 8'h00, 6'd32, 1'b0, 32'h0, ST_OK}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (n = 0; n < DIRECTED_ROWS; n++) begin
         send(dir_rows[n].op, dir_rows[n].data, dir_rows[n].size, dir_rows[n].fixed,
              dir_rows[n].value, dir_rows[n].status);
         rest(pick_gap());
      end

      // random part: mostly fields that fit the buffered bits, some noise
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == 150) hold_request = 1'b1;
         steady = (n >= 400 && n < 520);
         if (n == 700) begin
            // wait for every response before going on
            req_valid <= 1'b0;
            @(negedge clock);
            while (pending_fields.size() != 0) @(negedge clock);
         end
         pick = $urandom_range(0, 99);
         data = BYTE_W'($urandom_range(0, 255));
         if (pick < 8) begin
            op = OP_W'($urandom_range(0, 3));
            size = SIZE_W'($urandom_range(0, 63));
         end else if (pick < 12) begin
            op = OP_PUSH;
            size = SIZE_W'($urandom_range(0, 63));
         end else if (shadow_count + BYTE_BITS <= STORE_BITS &&
                      (shadow_count < FIELD_MAX ? $urandom_range(0, 3) != 0
                                                : $urandom_range(0, 2) == 0)) begin
            op = OP_PUSH;
            size = SIZE_W'($urandom_range(0, 63));
         end else begin
            op = $urandom_range(0, 1) ? OP_READ_S : OP_READ_U;
            lo = (op == OP_READ_S) ? 1 : 0;
            hi = (shadow_count < FIELD_MAX) ? shadow_count : FIELD_MAX;
            if (hi < lo) hi = lo;
            size = SIZE_W'($urandom_range(lo, hi));
         end
         send(op, data, size, 1'b0, 32'h0, ST_OK);
         rest(pick_gap());
      end
      steady = 1'b0;

      // drain
      req_valid <= 1'b0;
      while (pending_fields.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d requests sent, %0d responses checked", sent_count, checked_count);
      $display("by status: ok %0d, underrun %0d, full %0d, bad size %0d",
               status_tally[ST_OK], status_tally[ST_UNDERRUN],
               status_tally[ST_FULL], status_tally[ST_BAD_SIZE]);
      if (fault_count == 0) begin
         $display("[lsb_first_bit_field_reader] OK");
      end else begin
         $display("[lsb_first_bit_field_reader] ERROR");
      end
      $finish;
   end

endmodule
